### sv/mtbd_pkg.sv
// Package: shared constants, types and helper functions for the bounded-draw generator.
`default_nettype none
package mtbd_pkg;
  localparam int STATE_WORDS = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int IDX_W = 10;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [31:0] SEED_MULT = 32'd69069;
  localparam logic [31:0] SEED_RESET = 32'd4355;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] UNSEEDED_IDX = IDX_W'(STATE_WORDS + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEED, ST_TW_RD0, ST_TW_RD1, ST_TW_RD2, ST_TW_WR,
    ST_FETCH, ST_TEMPER, ST_DIV, ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_bound;
    logic seed_start;
    logic seed_step;
    logic tw_rd_k;
    logic tw_rd_k1;
    logic tw_rd_km;
    logic tw_write;
    logic fetch;
    logic temper;
    logic div_start;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic seed_done;
    logic tw_done;
    logic div_done;
  } dp_sts_t;

  function automatic logic [31:0] temper_word(input logic [31:0] w_in);
    logic [31:0] w;
    w = w_in;
    w = w ^ (w >> 11);
    w = w ^ ((w << 7) & 32'h9d2c5680);
    w = w ^ ((w << 15) & 32'hefc60000);
    w = w ^ (w >> 18);
    return w;
  endfunction
endpackage
`default_nettype wire

### sv/mt19937_bounded_draw_core.sv
// Top level: MT19937 bounded-draw generator with stream ports.
// Each input word carries a bound; the output word is the next tempered MT19937
// word modulo that bound, or 0 for a zero bound (generator untouched). A new
// bound is taken only once the previous draw has been loaded to the output; the
// remainder comes from a one-bit-per-cycle restoring divider. The first draw
// after reset or a seed write first seeds the 624-word RAM and then twists it;
// each twisted word is read and written through the single RAM port, in the
// states TW_RD0, TW_RD1, TW_RD2 and TW_WR. One item is in work at a time.
`default_nettype none
module mt19937_bounded_draw_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // bound[31:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // value[31:0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);
  import mtbd_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        idx_use, idx_set_end, idx_at_end;
  logic [31:0] seed_r;

  // hold the seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_valid) begin
      seed_r <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  mtbd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .bound(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_valid(cfg_valid), .idx_at_end(idx_at_end), .sts(sts), .cmd(cmd),
    .idx_use(idx_use), .idx_set_end(idx_set_end)
  );

  mtbd_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .seed(seed_r),
    .bound(in_tdata), .idx_use(idx_use), .idx_set_end(idx_set_end),
    .idx_at_end(idx_at_end), .result(out_tdata)
  );
endmodule
`default_nettype wire

### sv/mtbd_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module mtbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

### sv/mtbd_datapath.sv
// Datapath: word store, seeding, twisting, tempering and restoring divider.
`default_nettype none
module mtbd_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire mtbd_pkg::dp_cmd_t cmd,
  output mtbd_pkg::dp_sts_t      sts,
  input  wire logic [31:0]      seed,
  input  wire logic [31:0]      bound,
  input  wire logic             idx_use,
  input  wire logic             idx_set_end,
  output logic                  idx_at_end,
  output logic [31:0]           result
);
  import mtbd_pkg::*;

  logic [IDX_W-1:0] word_idx_r, word_idx_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [IDX_W-1:0] addr;
  logic             we;
  logic [31:0]      wdata, rdata;
  logic [31:0]      seed_w_r, seed_w_nxt;
  logic [31:0]      wk_r, wk1_r;
  logic [31:0]      bound_r;
  logic [31:0]      quo_r;
  logic [32:0]      rem_r;
  logic [5:0]       cnt_r;
  logic [31:0]      result_r;
  logic [31:0]      mix;
  logic [32:0]      rem_sh;
  logic [IDX_W-1:0] k1, km;

  mtbd_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // neighbor indexes for the twist
  always_comb begin
    k1 = (k_r == LAST_IDX) ? '0 : k_r + 1'b1;
    km = (k_r >= IDX_W'(STATE_WORDS - TWIST_OFFSET)) ?
         k_r - IDX_W'(STATE_WORDS - TWIST_OFFSET) : k_r + IDX_W'(TWIST_OFFSET);
    mix = {wk_r[31], wk1_r[30:0]};
  end

  // address and write data select
  always_comb begin
    we = 1'b0;
    wdata = seed_w_r;
    addr = k_r;
    seed_w_nxt = seed_w_r;
    k_nxt = k_r;
    if (cmd.seed_start) begin
      k_nxt = '0;
      seed_w_nxt = seed;
    end
    if (cmd.seed_step) begin
      we = 1'b1;
      wdata = seed_w_r;
      seed_w_nxt = seed_w_r * SEED_MULT;
      k_nxt = (k_r == LAST_IDX) ? '0 : k_r + 1'b1;
    end
    if (cmd.tw_rd_k1) addr = k1;
    if (cmd.tw_rd_km) addr = km;
    if (cmd.tw_write) begin
      we = 1'b1;
      wdata = rdata ^ (mix >> 1) ^ (mix[0] ? TWIST_MATRIX : 32'd0);
      k_nxt = (k_r == LAST_IDX) ? '0 : k_r + 1'b1;
    end
    if (cmd.fetch) addr = word_idx_r;
  end

  // word index bookkeeping
  always_comb begin
    word_idx_nxt = word_idx_r;
    if (idx_set_end) word_idx_nxt = IDX_W'(STATE_WORDS);
    if (cmd.tw_write && k_r == LAST_IDX) word_idx_nxt = '0;
    if (idx_use) word_idx_nxt = word_idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_idx_r <= UNSEEDED_IDX;
      k_r <= '0;
    end else begin
      word_idx_r <= word_idx_nxt;
      k_r <= k_nxt;
    end
  end

  assign rem_sh = {rem_r[31:0], quo_r[31]};

  // payload registers: operands, divider, result
  always_ff @(posedge clk) begin
    seed_w_r <= seed_w_nxt;
    if (cmd.load_bound) bound_r <= bound;
    if (cmd.tw_rd_k1) wk_r <= rdata;
    if (cmd.tw_rd_km) wk1_r <= rdata;
    if (cmd.temper) quo_r <= temper_word(rdata);
    if (cmd.div_start) begin
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, bound_r}) begin
        rem_r <= rem_sh - {1'b0, bound_r};
      end else begin
        rem_r <= rem_sh;
      end
      quo_r <= {quo_r[30:0], 1'b0};
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.out_load) result_r <= (bound_r == '0) ? '0 : rem_r[31:0];
  end

  assign idx_at_end = word_idx_r >= IDX_W'(STATE_WORDS);
  assign sts.seed_done = cmd.seed_step && k_r == LAST_IDX;
  assign sts.tw_done = cmd.tw_write && k_r == LAST_IDX;
  assign sts.div_done = cmd.div_step && cnt_r == 6'd31;
  assign result = result_r;
endmodule
`default_nettype wire

### sv/mtbd_ctrl.sv
// Controller: sequences seeding, twist, fetch, divide and output handshake.
`default_nettype none
module mtbd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [31:0]       bound,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire logic              cfg_valid,
  input  wire logic              idx_at_end,
  input  wire mtbd_pkg::dp_sts_t sts,
  output mtbd_pkg::dp_cmd_t      cmd,
  output logic                   idx_use,
  output logic                   idx_set_end
);
  import mtbd_pkg::*;

  state_t state_r, state_nxt;
  logic   reseed_r, reseed_nxt;
  logic   ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      reseed_r <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      reseed_r <= reseed_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    reseed_nxt = reseed_r;
    ovalid_nxt = ovalid_r;
    cmd = '0;
    idx_use = 1'b0;
    idx_set_end = 1'b0;
    in_tready = 1'b0;
    if (out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_bound = 1'b1;
          if (bound == '0) begin
            state_nxt = ST_OUT;
          end else if (reseed_r) begin
            cmd.seed_start = 1'b1;
            reseed_nxt = 1'b0;
            state_nxt = ST_SEED;
          end else if (idx_at_end) begin
            state_nxt = ST_TW_RD0;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_SEED: begin
        cmd.seed_step = 1'b1;
        if (sts.seed_done) begin
          idx_set_end = 1'b1;
          state_nxt = ST_TW_RD0;
        end
      end
      ST_TW_RD0: begin
        cmd.tw_rd_k1 = 1'b0;
        state_nxt = ST_TW_RD1;
      end
      ST_TW_RD1: begin
        cmd.tw_rd_k1 = 1'b1;
        state_nxt = ST_TW_RD2;
      end
      ST_TW_RD2: begin
        cmd.tw_rd_km = 1'b1;
        state_nxt = ST_TW_WR;
      end
      ST_TW_WR: begin
        cmd.tw_write = 1'b1;
        state_nxt = sts.tw_done ? ST_FETCH : ST_TW_RD0;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_TEMPER;
      end
      ST_TEMPER: begin
        cmd.temper = 1'b1;
        cmd.div_start = 1'b1;
        idx_use = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_valid) reseed_nxt = 1'b1;
  end

  assign out_tvalid = ovalid_r;

  // a draw starts a seeding pass only from the idle state
  a_seed_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.seed_start |-> state_r == ST_IDLE) else $error("seed start outside idle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("output dropped");
endmodule
`default_nettype wire
